[hw/rtl/fit_pkg.sv]
// ----------------------------------------------------------------------------
// fit_pkg: shared types and helpers for the Frobenius irreducibility test
// Coefficient width, item structs, the job handed from the front end to the
// back end, and small modular arithmetic helpers over GF(p).
// ----------------------------------------------------------------------------
package fit_pkg;

    localparam int COEF_W            = 5;
    localparam int BIT_W             = 3;
    localparam int LOW_TERMS         = 4;
    localparam int DEFAULT_MAX_PRIME = 31;
    localparam int MIN_PRIME         = 5;
    localparam int QUEUE_DEPTH       = 2;

    typedef logic [COEF_W-1:0] coef_t;
    typedef logic [LOW_TERMS-1:0][COEF_W-1:0] quad_t;

    localparam coef_t PRIME_RESET = COEF_W'(5);

    typedef struct packed {
        coef_t coef_cubic;
        coef_t coef_square;
        coef_t coef_linear;
        coef_t coef_const;
    } fit_in_t;

    typedef struct packed {
        logic irreducible;
        logic root_found;
    } fit_out_t;

    typedef struct packed {
        coef_t s0;
        coef_t d1;
        coef_t d2;
        coef_t d3;
        quad_t g;
    } fit_job_t;

    function automatic coef_t add_mod(coef_t a, coef_t b, coef_t p);
        logic [COEF_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p})
        begin
            s = s - {1'b0, p};
        end
        return s[COEF_W-1:0];
    endfunction

    // A coefficient can be several multiples of p, so subtract 4p, 2p and p in turn.
    function automatic coef_t red_mod(coef_t a, coef_t p);
        logic [COEF_W+1:0] r;
        logic [COEF_W+1:0] m;
        r = {2'b00, a};
        for (int s = 2; s >= 0; s--)
        begin
            m = {2'b00, p} << s;
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return r[COEF_W-1:0];
    endfunction

    function automatic coef_t neg_mod(coef_t a, coef_t p);
        return (a == '0) ? coef_t'(0) : coef_t'(p - a);
    endfunction

endpackage

[hw/rtl/fit_ram.sv]
// ----------------------------------------------------------------------------
// fit_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/fit_front.sv]
// ----------------------------------------------------------------------------
// fit_front: input stage and job queue
// Reduces the coefficients mod p, derives the forward differences for the
// root scan and the reduction polynomial g, and queues the job.
// ----------------------------------------------------------------------------
module fit_front
    import fit_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  coef_t    p,
    input  logic     push,
    output logic     full,
    input  fit_in_t  in_item,
    output logic     job_valid,
    input  logic     job_pop,
    output fit_job_t job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    coef_t    a, b, c, d;
    coef_t    a2, a4, a6, b2, ab, abc;
    fit_job_t job_in;

    fit_job_t                 q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]           count_reg, count_next;
    logic                     do_push, do_pop;

    always_comb
    begin
        a   = red_mod(in_item.coef_cubic, p);
        b   = red_mod(in_item.coef_square, p);
        c   = red_mod(in_item.coef_linear, p);
        d   = red_mod(in_item.coef_const, p);
        a2  = add_mod(a, a, p);
        a4  = add_mod(a2, a2, p);
        a6  = add_mod(a4, a2, p);
        b2  = add_mod(b, b, p);
        ab  = add_mod(a, b, p);
        abc = add_mod(ab, c, p);
        job_in.s0   = d;
        job_in.d1   = add_mod(abc, coef_t'(1), p);
        job_in.d2   = add_mod(a6, b2, p);
        job_in.d3   = a6;
        job_in.g[0] = neg_mod(d, p);
        job_in.g[1] = neg_mod(c, p);
        job_in.g[2] = neg_mod(b, p);
        job_in.g[3] = neg_mod(a, p);
    end

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_pop && job_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

[hw/rtl/fit_back.sv]
// ----------------------------------------------------------------------------
// fit_back: root scan, power table build and Frobenius iteration
// Scans GF(p) for a root, builds the rows x^(ip) mod f into a RAM, then
// applies the Frobenius map p times with one shift-add lane per coefficient.
// ----------------------------------------------------------------------------
module fit_back
    import fit_pkg::*;
#(
    parameter int MAX_PRIME = DEFAULT_MAX_PRIME
) (
    input  logic     clk,
    input  logic     rst_n,
    input  coef_t    p,
    input  logic     job_valid,
    output logic     job_pop,
    input  fit_job_t job,
    output logic     res_valid,
    input  logic     res_ack,
    output fit_out_t res
);

    localparam int CNT_W = $clog2(MAX_PRIME);

    typedef logic [MAX_PRIME-1:0][COEF_W-1:0] lane_t;

    localparam lane_t ONE_VEC = lane_t'(1);
    localparam lane_t X_VEC   = lane_t'(1) << COEF_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROOT = 3'd1;
    localparam logic [2:0] ST_TBL  = 3'd2;
    localparam logic [2:0] ST_FRD  = 3'd3;
    localparam logic [2:0] ST_FMAC = 3'd4;
    localparam logic [2:0] ST_CHK  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]       state_reg, state_next;
    coef_t            s_reg, s_next, d1_reg, d1_next, d2_reg, d2_next, d3_reg, d3_next;
    quad_t            g_reg, g_next, tacc_reg, tacc_next;
    quad_t            tab_reg [MAX_PRIME];
    lane_t            h_reg, h_next, w_reg, w_next, acc_reg, acc_next, tt_reg, tt_next;
    logic [CNT_W-1:0] k_reg, k_next, row_reg, row_next, step_reg, step_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    fit_out_t         res_reg, res_next;

    logic [CNT_W-1:0] p_last;
    coef_t            top;
    quad_t            tcur;
    lane_t            h_up, t_add, mulx, w_shift, acc_mac, tt_mac, src, acc_fin, rd_lanes;
    logic             bitv;
    logic             ram_we;
    logic [CNT_W-1:0] ram_waddr;
    lane_t            ram_wdata;
    logic [COEF_W*MAX_PRIME-1:0] ram_rdata;

    assign p_last   = CNT_W'(p - 1'b1);
    assign top      = h_reg[p_last];
    assign tcur     = tab_reg[CNT_W'(top)];
    assign rd_lanes = ram_rdata;
    assign bitv     = w_reg[0][bit_reg];

    always_comb
    begin
        h_up  = '0;
        t_add = '0;
        for (int k = 1; k < MAX_PRIME; k++)
        begin
            h_up[k] = h_reg[k-1];
        end
        for (int k = 0; k < LOW_TERMS; k++)
        begin
            t_add[k] = tcur[k];
        end
        for (int k = 0; k < MAX_PRIME; k++)
        begin
            mulx[k] = (k < int'(p)) ? add_mod(h_up[k], t_add[k], p) : coef_t'(0);
        end
        w_shift = '0;
        for (int k = 0; k < MAX_PRIME - 1; k++)
        begin
            w_shift[k] = w_reg[k+1];
        end
        for (int k = 0; k < MAX_PRIME; k++)
        begin
            src[k]     = (bit_reg == '0) ? rd_lanes[k] : tt_reg[k];
            acc_mac[k] = add_mod(acc_reg[k], bitv ? src[k] : coef_t'(0), p);
            tt_mac[k]  = add_mod(src[k], src[k], p);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_next     = s_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        d3_next    = d3_reg;
        g_next     = g_reg;
        tacc_next  = tacc_reg;
        h_next     = h_reg;
        w_next     = w_reg;
        acc_next   = acc_reg;
        tt_next    = tt_reg;
        k_next     = k_reg;
        row_next   = row_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        res_next   = res_reg;
        acc_fin    = acc_reg;
        job_pop    = 1'b0;
        res_valid  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = row_reg;
        ram_wdata  = mulx;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    s_next     = job.s0;
                    d1_next    = job.d1;
                    d2_next    = job.d2;
                    d3_next    = job.d3;
                    g_next     = job.g;
                    tacc_next  = '0;
                    k_next     = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                s_next  = add_mod(s_reg, d1_reg, p);
                d1_next = add_mod(d1_reg, d2_reg, p);
                d2_next = add_mod(d2_reg, d3_reg, p);
                for (int j = 0; j < LOW_TERMS; j++)
                begin
                    tacc_next[j] = add_mod(tacc_reg[j], g_reg[j], p);
                end
                if (s_reg == '0)
                begin
                    res_next.irreducible = 1'b0;
                    res_next.root_found  = 1'b1;
                    state_next           = ST_DONE;
                end
                else if (k_reg == p_last)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = ONE_VEC;
                    h_next     = ONE_VEC;
                    k_next     = '0;
                    row_next   = CNT_W'(1);
                    state_next = ST_TBL;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_TBL:
            begin
                h_next = mulx;
                if (k_reg == p_last)
                begin
                    ram_we = 1'b1;
                    k_next = '0;
                    if (row_reg == p_last)
                    begin
                        w_next     = X_VEC;
                        acc_next   = '0;
                        row_next   = '0;
                        step_next  = '0;
                        state_next = ST_FRD;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_FRD, ST_FMAC:
            begin
                if (state_reg == ST_FRD && w_reg[0] != '0)
                begin
                    bit_next   = '0;
                    state_next = ST_FMAC;
                end
                else if (state_reg == ST_FMAC && bit_reg != BIT_W'(COEF_W - 1))
                begin
                    acc_next = acc_mac;
                    tt_next  = tt_mac;
                    bit_next = bit_reg + 1'b1;
                end
                else
                begin
                    if (state_reg == ST_FMAC)
                    begin
                        acc_fin = acc_mac;
                    end
                    acc_next   = acc_fin;
                    state_next = ST_FRD;
                    if (row_reg == p_last)
                    begin
                        w_next   = acc_fin;
                        acc_next = '0;
                        row_next = '0;
                        if (step_reg == p_last)
                        begin
                            state_next = ST_CHK;
                        end
                        else
                        begin
                            step_next = step_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        w_next   = w_shift;
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            ST_CHK:
            begin
                res_next.irreducible = (w_reg == X_VEC);
                res_next.root_found  = 1'b0;
                state_next           = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        d3_reg   <= d3_next;
        g_reg    <= g_next;
        tacc_reg <= tacc_next;
        h_reg    <= h_next;
        w_reg    <= w_next;
        acc_reg  <= acc_next;
        tt_reg   <= tt_next;
        k_reg    <= k_next;
        row_reg  <= row_next;
        step_reg <= step_next;
        bit_reg  <= bit_next;
        res_reg  <= res_next;
        if (state_reg == ST_ROOT)
        begin
            tab_reg[k_reg] <= tacc_reg;
        end
    end

    fit_ram #(
        .WIDTH(COEF_W * MAX_PRIME),
        .DEPTH(MAX_PRIME)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(row_reg),
        .rdata(ram_rdata)
    );

    a_res_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.irreducible && res.root_found))
        else $error("result flags both set");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_ROOT || state_reg == ST_TBL))
        else $error("table write outside build phase");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (job_valid && state_reg == ST_IDLE))
        else $error("job taken while busy");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !res_ack) |=> (state_reg == ST_DONE && $stable(res_reg)))
        else $error("pending result lost");

endmodule

[hw/rtl/frobenius_irreducibility_test_core.sv]
// ----------------------------------------------------------------------------
// frobenius_irreducibility_test_core: irreducibility test of x^p+ax^3+bx^2+cx+d
// Items carry the four low coefficients; each gives one result item with the
// irreducible and root_found flags.
//
// Input side is a queue: an item is taken when push is high and full is low.
// Result side is a queue: the oldest result is shown while empty is low and
// is taken when pop is high. cfg_we writes the prime p from cfg_wdata; p is
// clamped to the range 5 to MAX_PRIME and must only change while idle.
// The front end reduces the coefficients and queues up to two items, so
// new items are taken while the back end works or a result waits.
// Per item the back end scans GF(p) for a root, builds the power table row by
// row and then runs the p Frobenius passes, with one shift-add step per
// coefficient lane and one table row read at a time.
// Reset empties both queues and sets p to 5. A stalled receiver holds the
// result; the back end then waits with its next result until it is taken.
// ----------------------------------------------------------------------------
module frobenius_irreducibility_test_core
    import fit_pkg::*;
#(
    parameter int MAX_PRIME = DEFAULT_MAX_PRIME
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  fit_in_t  in_item,
    output logic     empty,
    input  logic     pop,
    output fit_out_t out_item,
    input  logic     cfg_we,
    input  coef_t    cfg_wdata
);

    coef_t    prime_reg;
    coef_t    p_eff;
    logic     job_valid, job_pop;
    fit_job_t job;
    logic     res_valid, res_ack;
    fit_out_t res;
    logic     out_valid_reg, out_valid_next;
    fit_out_t out_reg;

    always_comb
    begin
        if (prime_reg < COEF_W'(MIN_PRIME))
        begin
            p_eff = COEF_W'(MIN_PRIME);
        end
        else if (int'(prime_reg) > MAX_PRIME)
        begin
            p_eff = COEF_W'(MAX_PRIME);
        end
        else
        begin
            p_eff = prime_reg;
        end
    end

    fit_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .p        (p_eff),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .job_valid(job_valid),
        .job_pop  (job_pop),
        .job      (job)
    );

    fit_back #(
        .MAX_PRIME(MAX_PRIME)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .p        (p_eff),
        .job_valid(job_valid),
        .job_pop  (job_pop),
        .job      (job),
        .res_valid(res_valid),
        .res_ack  (res_ack),
        .res      (res)
    );

    assign res_ack  = !out_valid_reg;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ack)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg     <= PRIME_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                prime_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ack)
        begin
            out_reg <= res;
        end
    end

endmodule
